/* rtl/twhp_pkg.sv */
// ----------------------------------------------------------------------------
// twhp_pkg
// Shared constants and controller/datapath interface types for the windowed
// high-pass tap detector.
// ----------------------------------------------------------------------------
`default_nettype none

package twhp_pkg;

  localparam int WINDOW_DEPTH_DEF = 30;
  localparam int AXES             = 3;

  localparam int SAMPLE_W = 16;
  localparam int FILT_W   = 24;
  localparam int SUM_W    = 25;
  localparam int PROD_W   = 42;
  localparam int THR_W    = 15;
  localparam int ALPHA_W  = 16;
  localparam int BLANK_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLANKING_SAMPLES = 2'd2;

  localparam logic [THR_W-1:0]   THR_RESET   = 15'd2304;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd15833;
  localparam logic [BLANK_W-1:0] BLANK_RESET = 8'd10;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic accept;    // store incoming beat, advance ring
    logic prime;     // read oldest entry
    logic init;      // seed filters, read next entry
    logic mul;       // form products, read next entry
    logic scl;       // round, saturate, threshold
    logic decide;    // pick axis, compute skip
    logic wrap;      // reduce skip modulo depth, move start
    logic load_out;  // latch result into output register
  } twhp_cmd_t;

  typedef struct packed {
    logic full_next;  // window full once the current beat is stored
    logic last_step;  // final filter step of the pass
    logic tap;        // some axis crossed the threshold
    logic skip_ge;    // remaining skip still not below depth
  } twhp_sts_t;

endpackage

`default_nettype wire

/* rtl/twhp_datapath.sv */
// ----------------------------------------------------------------------------
// twhp_datapath
// Sample window memory, ring pointers, three parallel high-pass filters,
// crossing capture, skip arithmetic, configuration and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module twhp_datapath #(
  parameter int DEPTH = twhp_pkg::WINDOW_DEPTH_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire twhp_pkg::twhp_cmd_t               cmd,
  output twhp_pkg::twhp_sts_t                    sts,
  input  wire [twhp_pkg::IN_DATA_W-1:0]          in_data,
  input  wire                                    cfg_we,
  input  wire [twhp_pkg::CFG_IDX_W-1:0]          cfg_addr,
  input  wire [twhp_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  output logic                                   res_detected,
  output logic [1:0]                             res_axis
);

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SKIP_W = ((IDX_W > twhp_pkg::BLANK_W) ? IDX_W : twhp_pkg::BLANK_W) + 1;
  localparam int CMP_W  = (CNT_W > SKIP_W) ? CNT_W : SKIP_W;
  localparam int ROW_W  = twhp_pkg::AXES * twhp_pkg::SAMPLE_W;
  localparam int SCL_W  = twhp_pkg::PROD_W - 16;

  localparam logic [IDX_W:0]   DEPTH_I = (IDX_W+1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_M2 = CNT_W'(DEPTH - 2);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(DEPTH - 1);
  localparam logic [SKIP_W-1:0] DEPTH_S = SKIP_W'(DEPTH);

  localparam logic signed [SCL_W-1:0] F_MAX = SCL_W'(8388607);
  localparam logic signed [SCL_W-1:0] F_MIN = -SCL_W'(8388608);

  logic [ROW_W-1:0] mem [DEPTH];
  logic [ROW_W-1:0] rd_data_r;

  logic [IDX_W-1:0] start_r, ptr_r, step_r;
  logic [CNT_W-1:0] fill_r;
  logic [SKIP_W-1:0] skip_r;

  logic [twhp_pkg::THR_W-1:0]   thr_r;
  logic [twhp_pkg::ALPHA_W-1:0] alpha_r;
  logic [twhp_pkg::BLANK_W-1:0] blank_r;

  logic signed [twhp_pkg::FILT_W-1:0]   f_r    [twhp_pkg::AXES];
  logic signed [twhp_pkg::SAMPLE_W-1:0] prev_r [twhp_pkg::AXES];
  logic signed [twhp_pkg::PROD_W-1:0]   prod_r [twhp_pkg::AXES];
  logic [twhp_pkg::AXES-1:0]            found_r;
  logic [IDX_W-1:0]                     pos_r  [twhp_pkg::AXES];

  logic det_r;
  logic [1:0] axis_r;

  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       slot;
  logic [IDX_W:0]         slot_sum;
  logic [IDX_W:0]         start_inc;
  logic [IDX_W:0]         ptr_inc;
  logic [IDX_W:0]         start_skip;
  logic [IDX_W-1:0]       start_inc_w, ptr_inc_w, start_skip_w;
  logic                   full_now;

  logic signed [twhp_pkg::SAMPLE_W-1:0] cur   [twhp_pkg::AXES];
  logic signed [twhp_pkg::SUM_W-1:0]    sum   [twhp_pkg::AXES];
  logic signed [twhp_pkg::PROD_W-1:0]   prodn [twhp_pkg::AXES];
  logic signed [SCL_W-1:0]              scaled[twhp_pkg::AXES];
  logic signed [twhp_pkg::FILT_W-1:0]   fsat  [twhp_pkg::AXES];
  logic [twhp_pkg::AXES-1:0]            hit;

  logic [1:0]        sel_axis;
  logic [IDX_W-1:0]  sel_pos;
  logic [SKIP_W-1:0] skip_full;
  logic [CMP_W-1:0]  fill_ext, skip_ext;

  // ring arithmetic
  always_comb begin
    full_now    = (fill_r == DEPTH_C);
    slot_sum    = {1'b0, start_r} + (IDX_W+1)'(fill_r);
    slot        = (slot_sum >= DEPTH_I) ? IDX_W'(slot_sum - DEPTH_I) : slot_sum[IDX_W-1:0];
    start_inc   = {1'b0, start_r} + 1'b1;
    start_inc_w = (start_inc == DEPTH_I) ? '0 : start_inc[IDX_W-1:0];
    ptr_inc     = {1'b0, ptr_r} + 1'b1;
    ptr_inc_w   = (ptr_inc == DEPTH_I) ? '0 : ptr_inc[IDX_W-1:0];
    start_skip  = {1'b0, start_r} + {1'b0, skip_r[IDX_W-1:0]};
    start_skip_w = (start_skip >= DEPTH_I) ? IDX_W'(start_skip - DEPTH_I)
                                           : start_skip[IDX_W-1:0];
    rd_en   = cmd.prime | cmd.init | cmd.mul;
    rd_addr = cmd.prime ? start_r : ptr_r;
  end

  // filter arithmetic, one lane per axis
  always_comb begin
    for (int a = 0; a < twhp_pkg::AXES; a++) begin
      cur[a]    = $signed(rd_data_r[a*twhp_pkg::SAMPLE_W +: twhp_pkg::SAMPLE_W]);
      sum[a]    = twhp_pkg::SUM_W'(f_r[a]) + twhp_pkg::SUM_W'(cur[a])
                  - twhp_pkg::SUM_W'(prev_r[a]);
      prodn[a]  = twhp_pkg::PROD_W'($signed({1'b0, alpha_r})) * twhp_pkg::PROD_W'(sum[a]);
      scaled[a] = SCL_W'((prod_r[a] + twhp_pkg::PROD_W'(32768)) >>> 16);
      if (scaled[a] > F_MAX) begin
        fsat[a] = twhp_pkg::FILT_W'(F_MAX);
      end else if (scaled[a] < F_MIN) begin
        fsat[a] = twhp_pkg::FILT_W'(F_MIN);
      end else begin
        fsat[a] = scaled[a][twhp_pkg::FILT_W-1:0];
      end
      hit[a] = fsat[a] > $signed({{(twhp_pkg::FILT_W-twhp_pkg::THR_W){1'b0}}, thr_r});
    end
  end

  // first axis in X, Y, Z order wins
  always_comb begin
    if (found_r[0]) begin
      sel_axis = twhp_pkg::AXIS_X;
      sel_pos  = pos_r[0];
    end else if (found_r[1]) begin
      sel_axis = twhp_pkg::AXIS_Y;
      sel_pos  = pos_r[1];
    end else begin
      sel_axis = twhp_pkg::AXIS_Z;
      sel_pos  = pos_r[2];
    end
    skip_full = SKIP_W'(sel_pos) + SKIP_W'(blank_r);
    fill_ext  = CMP_W'(fill_r);
    skip_ext  = CMP_W'(skip_full);
  end

  always_comb begin
    sts.full_next = (fill_r >= DEPTH_M2 + 1'b1);
    sts.last_step = (step_r == LAST_STEP);
    sts.tap       = |found_r;
    sts.skip_ge   = (skip_r >= DEPTH_S);
  end

  // window memory
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[full_now ? start_r : slot] <= in_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= twhp_pkg::THR_RESET;
      alpha_r <= twhp_pkg::ALPHA_RESET;
      blank_r <= twhp_pkg::BLANK_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        twhp_pkg::REG_TAP_THRESHOLD:    thr_r   <= cfg_wdata[twhp_pkg::THR_W-1:0];
        twhp_pkg::REG_FILTER_ALPHA:     alpha_r <= cfg_wdata[twhp_pkg::ALPHA_W-1:0];
        twhp_pkg::REG_BLANKING_SAMPLES: blank_r <= cfg_wdata[twhp_pkg::BLANK_W-1:0];
        default: ;
      endcase
    end
  end

  // ring state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      fill_r  <= '0;
    end else begin
      if (cmd.accept) begin
        if (full_now) begin
          start_r <= start_inc_w;
        end else begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (cmd.decide && (|found_r)) begin
        fill_r <= (fill_ext > skip_ext) ? CNT_W'(fill_ext - skip_ext) : '0;
      end
      if (cmd.wrap && !sts.skip_ge) begin
        start_r <= start_skip_w;
      end
    end
  end

  // scan registers
  always_ff @(posedge clk) begin
    if (cmd.prime) begin
      ptr_r <= start_inc_w;
    end else if (cmd.init || cmd.mul) begin
      ptr_r <= ptr_inc_w;
    end
    if (cmd.init) begin
      step_r <= IDX_W'(1);
    end else if (cmd.scl) begin
      step_r <= step_r + 1'b1;
    end
    if (cmd.decide) begin
      skip_r <= skip_full;
    end else if (cmd.wrap && sts.skip_ge) begin
      skip_r <= skip_r - DEPTH_S;
    end
    for (int a = 0; a < twhp_pkg::AXES; a++) begin
      if (cmd.init) begin
        f_r[a]     <= twhp_pkg::FILT_W'(cur[a]);
        prev_r[a]  <= cur[a];
        found_r[a] <= 1'b0;
      end else if (cmd.mul) begin
        prod_r[a] <= prodn[a];
        prev_r[a] <= cur[a];
      end else if (cmd.scl) begin
        f_r[a] <= fsat[a];
        if (hit[a] && !found_r[a]) begin
          found_r[a] <= 1'b1;
          pos_r[a]   <= step_r;
        end
      end
    end
  end

  // result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      det_r  <= 1'b0;
      axis_r <= twhp_pkg::AXIS_X;
    end else if (cmd.decide && (|found_r)) begin
      det_r  <= 1'b1;
      axis_r <= sel_axis;
    end
    if (cmd.load_out) begin
      res_detected <= det_r;
      res_axis     <= axis_r;
    end
  end

endmodule

`default_nettype wire

/* rtl/twhp_ctrl.sv */
// ----------------------------------------------------------------------------
// twhp_ctrl
// Sequencer for the tap detector: accept, filter pass, skip, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module twhp_ctrl (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_tvalid,
  output logic                     in_tready,
  output logic                     out_tvalid,
  input  wire                      out_tready,
  output twhp_pkg::twhp_cmd_t      cmd,
  input  wire twhp_pkg::twhp_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRIME, ST_INIT, ST_MUL, ST_SCL, ST_DECIDE, ST_WRAP, ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.full_next ? ST_PRIME : ST_DONE;
        end
      end
      ST_PRIME: begin
        cmd.prime = 1'b1;
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SCL;
      end
      ST_SCL: begin
        cmd.scl   = 1'b1;
        state_nxt = sts.last_step ? ST_DECIDE : ST_MUL;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.tap ? ST_WRAP : ST_DONE;
      end
      ST_WRAP: begin
        cmd.wrap = 1'b1;
        if (!sts.skip_ge) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/windowed_highpass_tap_detector_top.sv */
// While the window fills, an accepted beat goes straight to the result hand-off; once
//   full, a filter pass follows, plus wrap steps after a tap, skip = position + blanking.
// One beat at a time: a new beat is taken only in the idle state, after the filter
//   pass (multiply then round per window entry, three axes in parallel) and hand-off.
// A finished result waits in the output register while the next beat enters.
// Reset (rst_n low, synchronous): empty window, start 0, registers to defaults.
// ----------------------------------------------------------------------------
// windowed_highpass_tap_detector_top
// Three-axis windowed RC high-pass tap detector with stream ports.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_highpass_tap_detector_top #(
  parameter int DEPTH = twhp_pkg::WINDOW_DEPTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire [twhp_pkg::IN_DATA_W-1:0]        in_tdata,   // accel_x, accel_y, accel_z
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [twhp_pkg::OUT_DATA_W-1:0]      out_tdata,  // tap_detected, tap_axis, 5'b0
  input  wire                                  cfg_we,
  input  wire [twhp_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  wire [twhp_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  twhp_pkg::twhp_cmd_t cmd;
  twhp_pkg::twhp_sts_t sts;
  logic                res_detected;
  logic [1:0]          res_axis;

  twhp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  twhp_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_data      (in_tdata),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .res_detected (res_detected),
    .res_axis     (res_axis)
  );

  assign out_tdata = {5'b0, res_axis, res_detected};

endmodule

`default_nettype wire

/* verif/windowed_highpass_tap_detector_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_highpass_tap_detector_top_tb
// Self-checking bench for the windowed high-pass tap detector. A scoreboard
// keeps its own copy of the sample ring and registers, reruns the fixed-point
// filter on every accepted beat once its ring is full and checks each result
// beat in order. Stimulus is a short run of extreme samples, a threshold-equality
// sequence, then phases of quiet baseline with spikes and raw noise under varied
// register settings, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module windowed_highpass_tap_detector_top_tb;
  import twhp_pkg::*;

  localparam int          RUN_ITEMS  = 1400;
  localparam int unsigned CYCLE_CAP  = 1_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic       detected;
    logic [1:0] axis;
  } tap_result_t;

  class tap_scoreboard;
    logic [SAMPLE_W-1:0] ring [AXES][WINDOW_DEPTH_DEF];
    int unsigned         head;
    int unsigned         fill;
    logic [THR_W-1:0]    threshold;
    logic [ALPHA_W-1:0]  alpha;
    logic [BLANK_W-1:0]  blanking;
    tap_result_t         pending_q[$];
    int unsigned         errors;

    function new();
      head      = 0;
      fill      = 0;
      threshold = THR_RESET;
      alpha     = ALPHA_RESET;
      blanking  = BLANK_RESET;
      errors    = 0;
      foreach (ring[a, i]) ring[a][i] = '0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_TAP_THRESHOLD:    threshold = val[THR_W-1:0];
        REG_FILTER_ALPHA:     alpha     = val[ALPHA_W-1:0];
        REG_BLANKING_SAMPLES: blanking  = val[BLANK_W-1:0];
        default: ;
      endcase
    endfunction

    // position of the first filtered value above threshold, 0 if none
    function int unsigned crossing_pos(input int axis);
      longint      prev, filt, cur, coef, thr, q;
      int unsigned i;
      coef = alpha;
      thr  = threshold;
      prev = $signed(ring[axis][head]);
      filt = prev;
      for (i = 1; i < WINDOW_DEPTH_DEF; i++) begin
        cur  = $signed(ring[axis][(head + i) % WINDOW_DEPTH_DEF]);
        q    = coef * (filt + cur - prev) + 64'sd32768;
        filt = q >>> 16;
        if (filt > 64'sd8388607) filt = 64'sd8388607;
        if (filt < -64'sd8388608) filt = -64'sd8388608;
        prev = cur;
        if (filt > thr) return i;
      end
      return 0;
    endfunction

    function void note_sample(input logic [SAMPLE_W-1:0] x, y, z);
      int unsigned slot, pos, skip;
      tap_result_t r;
      if (fill < WINDOW_DEPTH_DEF) begin
        slot = (head + fill) % WINDOW_DEPTH_DEF;
        fill++;
      end else begin
        slot = head;
        head = (head + 1) % WINDOW_DEPTH_DEF;
      end
      ring[0][slot] = x;
      ring[1][slot] = y;
      ring[2][slot] = z;
      r = '0;
      if (fill == WINDOW_DEPTH_DEF) begin
        for (int a = 0; a < AXES; a++) begin
          pos = crossing_pos(a);
          if (pos != 0) begin
            skip       = pos + blanking;
            r.detected = 1'b1;
            r.axis     = a[1:0];
            head       = (head + skip) % WINDOW_DEPTH_DEF;
            fill       = (fill > skip) ? fill - skip : 0;
            break;
          end
        end
      end
      pending_q.push_back(r);
    endfunction

    task report(input string msg);
      errors++;
      $display("[%0t] tap result mismatch: %s", $time, msg);
    endtask

    task check_result(input logic [OUT_DATA_W-1:0] beat);
      tap_result_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected beat 0x%02h", beat));
      end else begin
        want = pending_q.pop_front();
        if (beat[0] !== want.detected)
          report($sformatf("tap_detected %b, want %b", beat[0], want.detected));
        if (beat[2:1] !== want.axis)
          report($sformatf("tap_axis %0d, want %0d", beat[2:1], want.axis));
        if (beat[OUT_DATA_W-1:3] !== '0)
          report($sformatf("padding bits 0x%02h not zero", beat));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;    // accel_x, accel_y, accel_z
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // tap_detected, tap_axis, 5'b0
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tap_scoreboard sb;
  bit            idle_in;
  bit            idle_out;
  int            stall_left;
  int unsigned   cycles = 0;

  windowed_highpass_tap_detector_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("** windowed_highpass_tap_detector_top: FAILED **");
      $finish;
    end
  end

  // result side: random stall after each beat
  always @(posedge clk) begin
    int wait_n;
    if (!rst_n) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
      wait_n = idle_out ? int'($urandom_range(0, 15)) : 0;
      if (wait_n != 0) begin
        out_tready <= 1'b0;
        stall_left <= wait_n - 1;
      end else begin
        out_tready <= 1'b1;
        stall_left <= 0;
      end
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic write_one(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // upper bits beyond each register are filled with noise
  task automatic set_config(input logic [THR_W-1:0] thr,
                            input logic [ALPHA_W-1:0] alpha,
                            input logic [BLANK_W-1:0] blank);
    logic       thr_pad;
    logic [7:0] blank_pad;
    thr_pad   = 1'($urandom_range(0, 1));
    blank_pad = 8'($urandom_range(0, 255));
    write_one(REG_TAP_THRESHOLD, {thr_pad, thr});
    write_one(REG_FILTER_ALPHA, alpha);
    write_one(REG_BLANKING_SAMPLES, {blank_pad, blank});
    write_one(REG_UNMAPPED, 16'($urandom_range(0, 65535)));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] x, y, z);
    int unsigned gap;
    gap = idle_in ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample(x, y, z);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [SAMPLE_W-1:0] pat [8];
    int                  sent, phase, kind, count;
    int                  base [3];
    int                  v [3];
    int                  spike_left, spike_axis, spike_amp, r;

    sb         = new();
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_we     <= 1'b0;
    cfg_addr   <= REG_TAP_THRESHOLD;
    cfg_wdata  <= '0;
    idle_in    = 1'b0;
    idle_out   = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extreme sample values at reset settings
    pat = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
            16'h0001, 16'h5555, 16'hAAAA, 16'h7FFE};
    for (int i = 0; i < 25; i++)
      send_sample(pat[i % 8], pat[(i + 3) % 8], pat[(i + 5) % 8]);
    drain_results();

    // filtered value equal to the threshold, then one step above it
    idle_in  = 1'b1;
    idle_out = 1'b1;
    set_config(15'd1000, 16'd32768, 8'd0);
    for (int i = 0; i < 34; i++) send_sample('0, '0, '0);
    send_sample(16'd2000, '0, '0);
    for (int i = 0; i < 30; i++) send_sample('0, '0, '0);
    send_sample(16'd2002, '0, '0);
    for (int i = 0; i < 5; i++) send_sample('0, '0, '0);
    drain_results();

    sent  = 0;
    phase = 0;
    while (sent < RUN_ITEMS) begin
      kind = (phase < 8) ? phase : $urandom_range(0, 7);
      case (kind)
        0: set_config(THR_RESET, ALPHA_RESET, BLANK_RESET);
        1: set_config(15'd0, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 20)));
        2: set_config(15'd32767, 16'd65535, 8'($urandom_range(0, 255)));
        3: set_config(15'd0, 16'd0, 8'($urandom_range(0, 255)));
        4: set_config(15'($urandom_range(0, 4000)), 16'd65535, 8'd0);
        5: set_config(15'($urandom_range(1000, 6000)), 16'($urandom_range(0, 65535)),
                      8'd0);
        6: set_config(15'($urandom_range(500, 5000)), 16'($urandom_range(8000, 65535)),
                      8'd255);
        default: set_config(15'($urandom_range(0, 32767)),
                            16'($urandom_range(0, 65535)),
                            8'($urandom_range(0, 255)));
      endcase
      idle_in    = $urandom_range(0, 3) != 0;
      idle_out   = $urandom_range(0, 3) != 0;
      count      = $urandom_range(60, 180);
      spike_left = 0;
      foreach (base[a]) base[a] = int'($urandom_range(0, 8000)) - 4000;
      for (int n = 0; n < count; n++) begin
        r = $urandom_range(0, 99);
        foreach (v[a]) v[a] = base[a] + int'($urandom_range(0, 600)) - 300;
        if (spike_left == 0 && r < 8) begin
          spike_axis = $urandom_range(0, 2);
          spike_amp  = $urandom_range(1000, 28000);
          if ($urandom_range(0, 1)) spike_amp = -spike_amp;
          spike_left = $urandom_range(1, 3);
        end
        if (spike_left > 0) begin
          v[spike_axis] = base[spike_axis] + spike_amp;
          spike_left--;
        end else if (r < 23) begin
          foreach (v[a]) v[a] = $urandom_range(0, 65535);
        end
        send_sample(v[0][15:0], v[1][15:0], v[2][15:0]);
      end
      sent += count;
      phase++;
      drain_results();
    end

    repeat (2 * WINDOW_DEPTH_DEF + 16) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("** windowed_highpass_tap_detector_top: PASSED **");
    end else begin
      $display("** windowed_highpass_tap_detector_top: FAILED **");
    end
    $finish;
  end

endmodule
